// ===== rtl/sampled_pair_dot_product_assert.svh =====
// Assertion macros for the sampled pair dot product block.
// Used by the top level only; needs nothing else.
`ifndef SAMPLED_PAIR_DOT_PRODUCT_ASSERT_SVH
`define SAMPLED_PAIR_DOT_PRODUCT_ASSERT_SVH

// same-cycle implication
`define SPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/spd_pkg.sv =====
// Shared types, constants and the saturating add of the sampled pair dot product.
// No dependencies.
`default_nettype none

package spd_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int RANK_W = 5;
    localparam int MODE_W = 2;
    localparam int POS_W  = 4;
    localparam int IDX_W  = 8;

    localparam logic [RANK_W-1:0] RANK_RESET = 5'd16;

    localparam logic [MODE_W-1:0] MODE_LOAD_U = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_V = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
    } chain_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0]   sum;
        logic signed [ACC_W-1:0] res;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            res = sum[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]              wdata,
    input  wire logic                          re,
    input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/spd_cell.sv =====
// One rank position: its U column and V row stores, one multiplier and one
// saturating accumulate stage of the chain. Depends on spd_pkg and spd_ram.
`default_nettype none

module spd_cell #(
    parameter int ROWS = 256,
    parameter int COLS = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   u_we,
    input  wire logic                                   v_we,
    input  wire logic [(ROWS>1 ? $clog2(ROWS) : 1)-1:0] u_addr,
    input  wire logic [(COLS>1 ? $clog2(COLS) : 1)-1:0] v_addr,
    input  wire logic [spd_pkg::DATA_W-1:0]             wr_data,
    input  wire logic                                   rd_en,
    input  wire logic                                   mul_en,
    input  wire logic                                   active,
    input  wire spd_pkg::chain_t                        chain_in,
    output spd_pkg::chain_t                             chain_out
);

    logic        [spd_pkg::DATA_W-1:0] u_rdata;
    logic        [spd_pkg::DATA_W-1:0] v_rdata;
    logic signed [spd_pkg::DATA_W-1:0] u_val;
    logic signed [spd_pkg::DATA_W-1:0] v_val;
    logic signed [spd_pkg::ACC_W-1:0]  product_reg;
    logic signed [spd_pkg::ACC_W-1:0]  product_next;
    logic                              valid_reg;
    logic signed [spd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [spd_pkg::ACC_W-1:0]  acc_next;

    spd_ram #(.WIDTH(spd_pkg::DATA_W), .DEPTH(ROWS)) u_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (u_addr),
        .rdata (u_rdata)
    );

    spd_ram #(.WIDTH(spd_pkg::DATA_W), .DEPTH(COLS)) v_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (v_addr),
        .rdata (v_rdata)
    );

    assign u_val        = $signed(u_rdata);
    assign v_val        = $signed(v_rdata);
    assign product_next = spd_pkg::ACC_W'(u_val) * spd_pkg::ACC_W'(v_val);
    assign acc_next     = active ? spd_pkg::sat_add(chain_in.acc, product_reg) : chain_in.acc;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            product_reg <= product_next;
        end
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= chain_in.valid;
        end
    end

    assign chain_out.valid = valid_reg;
    assign chain_out.acc   = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/sampled_pair_dot_product.sv =====
// Query: accepted at start; the U and V reads, then the products are registered,
// then the chain of cell accumulators sums them to result_strobe. Busy meanwhile,
// so no query or load is taken until the result. Loads may follow back to back.
// Reset: rank_reg returns to 16, the chain empties; store contents are undefined.
// Top level: row of rank cells, read/multiply launch control, config register.
// Depends on spd_pkg, spd_cell, spd_ram and sampled_pair_dot_product_assert.svh.
`default_nettype none

`include "sampled_pair_dot_product_assert.svh"

module sampled_pair_dot_product #(
    parameter int MAX_RANK = 16,
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [spd_pkg::MODE_W-1:0]        mode,
    input  wire logic [spd_pkg::IDX_W-1:0]         u_row,
    input  wire logic [spd_pkg::IDX_W-1:0]         v_col,
    input  wire logic [spd_pkg::POS_W-1:0]         rank_pos,
    input  wire logic signed [spd_pkg::DATA_W-1:0] load_value,
    output logic                                   result_strobe,
    output logic signed [spd_pkg::ACC_W-1:0]       product_sum,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [spd_pkg::RANK_W-1:0]        cfg_data
);

    localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int IDX_N = 1 << spd_pkg::IDX_W;
    localparam int CMP_W = 8;

    logic                       busy_reg;
    logic                       busy_next;
    logic                       rd_reg;
    logic                       mul_reg;
    logic [spd_pkg::RANK_W-1:0] rank_reg;
    logic                       accept;
    logic                       accept_query;
    logic                       accept_load_u;
    logic                       accept_load_v;
    logic [RAW-1:0]             row_map [IDX_N];
    logic [CAW-1:0]             col_map [IDX_N];
    logic [RAW-1:0]             row_idx;
    logic [CAW-1:0]             col_idx;
    spd_pkg::chain_t            launch;
    spd_pkg::chain_t            chain [MAX_RANK];
    logic [MAX_RANK-1:0]        chain_valid;

    // index wrap tables (constant)
    for (genvar i = 0; i < IDX_N; i++)
    begin : g_map
        assign row_map[i] = RAW'(i % MAX_ROWS);
        assign col_map[i] = CAW'(i % MAX_COLS);
    end

    assign accept        = start && !busy_reg;
    assign accept_query  = accept && (mode == spd_pkg::MODE_QUERY);
    assign accept_load_u = accept && (mode == spd_pkg::MODE_LOAD_U);
    assign accept_load_v = accept && (mode == spd_pkg::MODE_LOAD_V);
    assign row_idx       = row_map[u_row];
    assign col_idx       = col_map[v_col];

    assign busy_next = accept_query ? 1'b1 :
                       (chain[MAX_RANK-1].valid ? 1'b0 : busy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rd_reg   <= 1'b0;
            mul_reg  <= 1'b0;
            rank_reg <= spd_pkg::RANK_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            rd_reg   <= accept_query;
            mul_reg  <= rd_reg;
            if (cfg_valid && cfg_ready)
            begin
                rank_reg <= cfg_data;
            end
        end
    end

    assign launch.valid = mul_reg;
    assign launch.acc   = '0;

    for (genvar k = 0; k < MAX_RANK; k++)
    begin : g_cell
        logic            active;
        logic            pos_hit;
        spd_pkg::chain_t cin;

        assign active  = CMP_W'(rank_reg) > CMP_W'(k);
        assign pos_hit = CMP_W'(rank_pos) == CMP_W'(k);

        if (k == 0)
        begin : g_first
            assign cin = launch;
        end
        else
        begin : g_next
            assign cin = chain[k-1];
        end

        spd_cell #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) cell_i (
            .clk       (clk),
            .rst_n     (rst_n),
            .u_we      (accept_load_u && pos_hit),
            .v_we      (accept_load_v && pos_hit),
            .u_addr    (row_idx),
            .v_addr    (col_idx),
            .wr_data   (load_value),
            .rd_en     (accept_query),
            .mul_en    (rd_reg),
            .active    (active),
            .chain_in  (cin),
            .chain_out (chain[k])
        );

        assign chain_valid[k] = chain[k].valid;
    end

    assign busy          = busy_reg;
    assign cfg_ready     = !busy_reg;
    assign result_strobe = chain[MAX_RANK-1].valid;
    assign product_sum   = chain[MAX_RANK-1].acc;

    `SPD_ASSERT_IMP(a_one_query_in_chain, clk, rst_n, 1'b1, $onehot0({chain_valid, rd_reg, mul_reg}))
    `SPD_ASSERT_IMP(a_result_while_busy, clk, rst_n, result_strobe, busy_reg)
    `SPD_ASSERT_NEXT(a_idle_after_result, clk, rst_n, result_strobe, !busy_reg)
    `SPD_ASSERT_NEXT(a_query_sets_busy, clk, rst_n, accept_query, busy_reg && rd_reg)

endmodule

`default_nettype wire
